>>> hw/rtl/prrts_pkg.sv
// shared types and constants for the priority round-robin thread scheduler
// no dependencies; used by prrts_ctrl, prrts_dp and the top level
package prrts_pkg;

  localparam int ThreadSlots = 16;
  localparam int SlotW = $clog2(ThreadSlots);
  localparam int CntW = $clog2(ThreadSlots + 1);
  localparam int PrioW = 8;
  localparam int BestW = PrioW + 1;
  localparam int WordW = 32;
  localparam int GenW = 16;
  localparam int OpW = 3;
  localparam int StatW = 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 3'd0,
    OP_KILL_ID  = 3'd1,
    OP_KILL_CUR = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_BLOCK    = 3'd4,
    OP_TICK     = 3'd5,
    OP_SCHED    = 3'd6
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPRIO  = 3'd2,
    ST_NOKILL   = 3'd3,
    ST_NOTHREAD = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_UNLINK,
    S_WAKE,
    S_SCHED_INIT,
    S_SCHED_LOOP,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_WALK_INIT,
    CMD_WALK_STEP,
    CMD_UNLINK,
    CMD_SLEEP,
    CMD_BLOCK,
    CMD_WAKE_STEP,
    CMD_SCHED_INIT,
    CMD_SCHED_STEP,
    CMD_SCHED_END,
    CMD_OUTPUT
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic bad_prio;
    logic lt_two;
    logic cur_valid;
    logic cnt_done;
    logic id_match;
    logic walk_is_cur;
  } dp_stat_t;

endpackage

>>> hw/rtl/prrts_ctrl.sv
// sequencer for the thread scheduler: decodes the operation and steps the datapath
// depends on prrts_pkg
module prrts_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [prrts_pkg::OpW-1:0]     opcode_i,
  input  prrts_pkg::dp_stat_t           stat_i,
  output prrts_pkg::dp_cmd_t            cmd_o,
  output logic                          busy
);

  prrts_pkg::state_e state_q, state_d;
  logic [prrts_pkg::OpW-1:0] op_q, op_d;
  prrts_pkg::status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prrts_pkg::S_IDLE;
      op_q    <= '0;
      st_q    <= prrts_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    st_d = st_q;
    cmd_o.op = prrts_pkg::CMD_NONE;
    cmd_o.status = st_q;
    case (state_q)
      prrts_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.op = prrts_pkg::CMD_LOAD;
          op_d = opcode_i;
          st_d = prrts_pkg::ST_OK;
          state_d = prrts_pkg::S_DISPATCH;
        end
      end
      prrts_pkg::S_DISPATCH: begin
        state_d = prrts_pkg::S_OUT;
        case (op_q)
          prrts_pkg::OP_ADD: begin
            if (stat_i.full) st_d = prrts_pkg::ST_FULL;
            else if (stat_i.bad_prio) st_d = prrts_pkg::ST_BADPRIO;
            else cmd_o.op = prrts_pkg::CMD_ADD;
          end
          prrts_pkg::OP_KILL_ID: begin
            if (stat_i.lt_two) st_d = prrts_pkg::ST_NOKILL;
            else begin
              cmd_o.op = prrts_pkg::CMD_WALK_INIT;
              state_d = prrts_pkg::S_FIND;
            end
          end
          prrts_pkg::OP_KILL_CUR: begin
            if (!stat_i.cur_valid) st_d = prrts_pkg::ST_EMPTY;
            else if (stat_i.lt_two) st_d = prrts_pkg::ST_NOKILL;
            else begin
              cmd_o.op = prrts_pkg::CMD_WALK_INIT;
              state_d = prrts_pkg::S_UNLINK;
            end
          end
          prrts_pkg::OP_SLEEP: begin
            if (!stat_i.cur_valid) st_d = prrts_pkg::ST_EMPTY;
            else begin
              cmd_o.op = prrts_pkg::CMD_SLEEP;
              state_d = prrts_pkg::S_SCHED_INIT;
            end
          end
          prrts_pkg::OP_BLOCK: begin
            if (!stat_i.cur_valid) st_d = prrts_pkg::ST_EMPTY;
            else begin
              cmd_o.op = prrts_pkg::CMD_WALK_INIT;
              state_d = prrts_pkg::S_FIND;
            end
          end
          prrts_pkg::OP_TICK: begin
            if (!stat_i.cur_valid) st_d = prrts_pkg::ST_EMPTY;
            else begin
              cmd_o.op = prrts_pkg::CMD_WALK_INIT;
              state_d = prrts_pkg::S_WAKE;
            end
          end
          prrts_pkg::OP_SCHED: begin
            if (!stat_i.cur_valid) st_d = prrts_pkg::ST_EMPTY;
            else state_d = prrts_pkg::S_SCHED_INIT;
          end
          default: ;
        endcase
      end
      prrts_pkg::S_FIND: begin
        if (stat_i.cnt_done) begin
          st_d = prrts_pkg::ST_NOTHREAD;
          state_d = prrts_pkg::S_OUT;
        end else if (stat_i.id_match) begin
          if (op_q == prrts_pkg::OP_KILL_ID) state_d = prrts_pkg::S_UNLINK;
          else begin
            cmd_o.op = prrts_pkg::CMD_BLOCK;
            state_d = prrts_pkg::S_OUT;
          end
        end else begin
          cmd_o.op = prrts_pkg::CMD_WALK_STEP;
        end
      end
      prrts_pkg::S_UNLINK: begin
        cmd_o.op = prrts_pkg::CMD_UNLINK;
        if (op_q == prrts_pkg::OP_KILL_CUR || stat_i.walk_is_cur)
          state_d = prrts_pkg::S_SCHED_INIT;
        else
          state_d = prrts_pkg::S_OUT;
      end
      prrts_pkg::S_WAKE: begin
        if (stat_i.cnt_done) state_d = prrts_pkg::S_SCHED_INIT;
        else cmd_o.op = prrts_pkg::CMD_WAKE_STEP;
      end
      prrts_pkg::S_SCHED_INIT: begin
        cmd_o.op = prrts_pkg::CMD_SCHED_INIT;
        state_d = prrts_pkg::S_SCHED_LOOP;
      end
      prrts_pkg::S_SCHED_LOOP: begin
        if (stat_i.cnt_done) begin
          cmd_o.op = prrts_pkg::CMD_SCHED_END;
          state_d = prrts_pkg::S_OUT;
        end else begin
          cmd_o.op = prrts_pkg::CMD_SCHED_STEP;
        end
      end
      prrts_pkg::S_OUT: begin
        cmd_o.op = prrts_pkg::CMD_OUTPUT;
        state_d = prrts_pkg::S_IDLE;
      end
      default: state_d = prrts_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_q != prrts_pkg::S_IDLE);

endmodule

>>> hw/rtl/prrts_dp.sv
// slot table, ring links, walk pointer and result registers of the thread scheduler
// depends on prrts_pkg
module prrts_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  prrts_pkg::dp_cmd_t              cmd_i,
  output prrts_pkg::dp_stat_t             stat_o,
  input  logic [prrts_pkg::OpW-1:0]       opcode_i,
  input  logic [prrts_pkg::PrioW-1:0]     priority_req_i,
  input  logic [prrts_pkg::WordW-1:0]     target_id_i,
  input  logic [prrts_pkg::WordW-1:0]     sleep_ticks_i,
  input  logic                            block_flag_i,
  input  logic                            cfg_we_i,
  input  logic [prrts_pkg::PrioW-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output logic [prrts_pkg::StatW-1:0]     status_o,
  output logic [prrts_pkg::SlotW-1:0]     running_slot_o,
  output logic                            running_valid_o,
  output logic [prrts_pkg::WordW-1:0]     running_thread_id_o,
  output logic [prrts_pkg::WordW-1:0]     added_id_o
);

  localparam int N = prrts_pkg::ThreadSlots;
  localparam int SW = prrts_pkg::SlotW;
  localparam int CW = prrts_pkg::CntW;
  localparam int PW = prrts_pkg::PrioW;
  localparam int BW = prrts_pkg::BestW;
  localparam int WW = prrts_pkg::WordW;
  localparam int GW = prrts_pkg::GenW;

  // per-slot storage
  logic [N-1:0]  alive_q;
  logic [PW-1:0] prio_q [N];
  logic          blk_q [N];
  logic          slp_q [N];
  logic [WW-1:0] wake_q [N];
  logic [SW-1:0] next_q [N];
  logic [SW-1:0] prev_q [N];
  logic [GW-1:0] gen_q [N];

  // control state
  logic [CW-1:0] total_q;
  logic [SW-1:0] cur_q;
  logic          cur_valid_q;
  logic [GW-1:0] gen_cnt_q;
  logic [WW-1:0] time_q;
  logic [PW-1:0] max_prio_q;

  // walk state
  logic [SW-1:0] walk_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] first_q;
  logic [SW-1:0] pick_q;
  logic [BW-1:0] best_q;
  logic          found_q;

  // latched operands
  logic [PW-1:0] prio_in_q;
  logic [WW-1:0] target_q;
  logic [WW-1:0] ticks_q;
  logic          flag_q;
  logic [WW-1:0] added_q;

  logic [SW-1:0] raddr;
  logic [SW-1:0] free_slot;
  logic [SW-1:0] rd_next, rd_prev;
  logic [PW-1:0] rd_prio;
  logic [GW-1:0] rd_gen;
  logic          rd_blk, rd_slp;
  logic [WW-1:0] rd_wake;
  logic          ready;

  always_comb begin
    case (cmd_i.op)
      prrts_pkg::CMD_ADD, prrts_pkg::CMD_SCHED_INIT, prrts_pkg::CMD_OUTPUT: raddr = cur_q;
      default: raddr = walk_q;
    endcase
  end

  assign rd_next = next_q[raddr];
  assign rd_prev = prev_q[raddr];
  assign rd_prio = prio_q[raddr];
  assign rd_gen  = gen_q[raddr];
  assign rd_blk  = blk_q[raddr];
  assign rd_slp  = slp_q[raddr];
  assign rd_wake = wake_q[raddr];
  assign ready   = !rd_blk && !rd_slp;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!alive_q[i]) free_slot = SW'(i);
    end
  end

  assign stat_o.full        = (total_q >= CW'(N));
  assign stat_o.bad_prio    = (prio_in_q > max_prio_q);
  assign stat_o.lt_two      = (total_q < CW'(2));
  assign stat_o.cur_valid   = cur_valid_q;
  assign stat_o.cnt_done    = (cnt_q == total_q);
  assign stat_o.id_match    = (rd_gen == target_q[WW-1:GW]) &&
                              (target_q[GW-1:0] == GW'(walk_q));
  assign stat_o.walk_is_cur = (walk_q == cur_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q     <= '0;
      total_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      gen_cnt_q   <= '0;
      time_q      <= '0;
      max_prio_q  <= '1;
      done_o      <= 1'b0;
    end else begin
      done_o <= (cmd_i.op == prrts_pkg::CMD_OUTPUT);
      if (cfg_we_i) max_prio_q <= cfg_wdata_i;
      case (cmd_i.op)
        prrts_pkg::CMD_LOAD: begin
          if (opcode_i == prrts_pkg::OP_TICK) time_q <= time_q + WW'(1);
        end
        prrts_pkg::CMD_ADD: begin
          alive_q[free_slot] <= 1'b1;
          total_q <= total_q + CW'(1);
          gen_cnt_q <= gen_cnt_q + GW'(1);
          if (!cur_valid_q) begin
            cur_q <= free_slot;
            cur_valid_q <= 1'b1;
          end
        end
        prrts_pkg::CMD_UNLINK: begin
          alive_q[walk_q] <= 1'b0;
          total_q <= total_q - CW'(1);
        end
        prrts_pkg::CMD_SCHED_END: begin
          if (!found_q && !alive_q[cur_q]) cur_q <= first_q;
          else cur_q <= pick_q;
        end
        default: ;
      endcase
    end
  end

  // slot tables, walk state and results
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      prrts_pkg::CMD_LOAD: begin
        prio_in_q <= priority_req_i;
        target_q  <= target_id_i;
        ticks_q   <= sleep_ticks_i;
        flag_q    <= block_flag_i;
        added_q   <= '0;
      end
      prrts_pkg::CMD_ADD: begin
        blk_q[free_slot]  <= 1'b0;
        slp_q[free_slot]  <= 1'b0;
        wake_q[free_slot] <= '0;
        prio_q[free_slot] <= prio_in_q;
        gen_q[free_slot]  <= gen_cnt_q;
        added_q <= {gen_cnt_q, GW'(free_slot)};
        if (!cur_valid_q) begin
          next_q[free_slot] <= free_slot;
          prev_q[free_slot] <= free_slot;
        end else begin
          next_q[rd_prev]   <= free_slot;
          prev_q[free_slot] <= rd_prev;
          next_q[free_slot] <= cur_q;
          prev_q[cur_q]     <= free_slot;
        end
      end
      prrts_pkg::CMD_WALK_INIT: begin
        walk_q <= cur_q;
        cnt_q  <= '0;
      end
      prrts_pkg::CMD_WALK_STEP: begin
        walk_q <= rd_next;
        cnt_q  <= cnt_q + CW'(1);
      end
      prrts_pkg::CMD_UNLINK: begin
        next_q[rd_prev] <= rd_next;
        prev_q[rd_next] <= rd_prev;
      end
      prrts_pkg::CMD_SLEEP: begin
        wake_q[cur_q] <= time_q + ticks_q;
        slp_q[cur_q]  <= 1'b1;
      end
      prrts_pkg::CMD_BLOCK: begin
        blk_q[walk_q] <= flag_q;
      end
      prrts_pkg::CMD_WAKE_STEP: begin
        if (rd_slp && rd_wake == time_q) slp_q[walk_q] <= 1'b0;
        walk_q <= rd_next;
        cnt_q  <= cnt_q + CW'(1);
      end
      prrts_pkg::CMD_SCHED_INIT: begin
        walk_q  <= rd_next;
        first_q <= rd_next;
        pick_q  <= cur_q;
        cnt_q   <= '0;
        best_q  <= BW'(1 << PW);
        found_q <= 1'b0;
      end
      prrts_pkg::CMD_SCHED_STEP: begin
        if (ready && ({1'b0, rd_prio} < best_q)) begin
          pick_q  <= walk_q;
          best_q  <= {1'b0, rd_prio};
          found_q <= 1'b1;
        end
        walk_q <= rd_next;
        cnt_q  <= cnt_q + CW'(1);
      end
      prrts_pkg::CMD_OUTPUT: begin
        status_o        <= cmd_i.status;
        running_valid_o <= cur_valid_q;
        running_slot_o  <= cur_valid_q ? cur_q : '0;
        running_thread_id_o <= cur_valid_q ? {rd_gen, GW'(cur_q)} : '0;
        added_id_o      <= added_q;
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/priority_round_robin_thread_scheduler_core.sv
// top level of the priority round-robin thread scheduler
// depends on prrts_pkg, prrts_ctrl and prrts_dp
//
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// command   | start / busy            | opcode_i, priority_req_i, target_id_i,
//           |                         | sleep_ticks_i, block_flag_i
// result    | done_o (one-cycle)      | status_o, running_slot_o, running_valid_o,
//           |                         | running_thread_id_o, added_id_o
// config    | cfg_we_i                | cfg_wdata_i (priority ceiling for add)
//
// add and early error answers walk no ring; set blocked and kill by id search the ring for
// the target; schedule, sleep and kill current walk the ring once to pick; kill by id of the
// running thread searches and then picks; tick walks once to wake sleepers and once to pick.
// the ring walks visit one slot per cycle
// reset: all slots free, priority ceiling 255, time and generation zero
// the result transfer cannot be stalled; done_o pulses in the first cycle with busy low
module priority_round_robin_thread_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [prrts_pkg::OpW-1:0]     opcode_i,
  input  logic [prrts_pkg::PrioW-1:0]   priority_req_i,
  input  logic [prrts_pkg::WordW-1:0]   target_id_i,
  input  logic [prrts_pkg::WordW-1:0]   sleep_ticks_i,
  input  logic                          block_flag_i,
  input  logic                          cfg_we_i,
  input  logic [prrts_pkg::PrioW-1:0]   cfg_wdata_i,
  output logic                          done_o,
  output logic [prrts_pkg::StatW-1:0]   status_o,
  output logic [prrts_pkg::SlotW-1:0]   running_slot_o,
  output logic                          running_valid_o,
  output logic [prrts_pkg::WordW-1:0]   running_thread_id_o,
  output logic [prrts_pkg::WordW-1:0]   added_id_o
);

  // command and status between sequencer and datapath
  prrts_pkg::dp_cmd_t  cmd;
  prrts_pkg::dp_stat_t stat;

  prrts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  prrts_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .opcode_i            (opcode_i),
    .priority_req_i      (priority_req_i),
    .target_id_i         (target_id_i),
    .sleep_ticks_i       (sleep_ticks_i),
    .block_flag_i        (block_flag_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .running_slot_o      (running_slot_o),
    .running_valid_o     (running_valid_o),
    .running_thread_id_o (running_thread_id_o),
    .added_id_o          (added_id_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the priority round-robin thread scheduler core
// depends on prrts_pkg and priority_round_robin_thread_scheduler_core
module testbench;

  localparam int NSlot = 16;
  // opcode with no operation behind it
  localparam logic [2:0] OpUnused = 3'd7;

  // one scheduler command as driven on the command ports
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  prio;
    logic [31:0] target;
    logic [31:0] ticks;
    logic        flag;
  } sched_cmd_t;

  // one scheduler answer as seen on the result ports
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  run_slot;
    logic        run_valid;
    logic [31:0] run_id;
    logic [31:0] added;
  } sched_ans_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode_i = '0;
  logic [7:0] priority_req_i = '0;
  logic [31:0] target_id_i = '0;
  logic [31:0] sleep_ticks_i = '0;
  logic block_flag_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [3:0] running_slot_o;
  logic running_valid_o;
  logic [31:0] running_thread_id_o;
  logic [31:0] added_id_o;

  always #5 clk_i = ~clk_i;

  priority_round_robin_thread_scheduler_core u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .priority_req_i, .target_id_i,
    .sleep_ticks_i, .block_flag_i, .cfg_we_i, .cfg_wdata_i, .done_o, .status_o,
    .running_slot_o, .running_valid_o, .running_thread_id_o, .added_id_o
  );

  // predictor copy of the thread table
  logic [7:0]  mdl_max_prio;
  logic        mdl_alive [NSlot];
  logic [7:0]  mdl_prio [NSlot];
  logic        mdl_blocked [NSlot];
  logic        mdl_asleep [NSlot];
  logic [31:0] mdl_wake [NSlot];
  logic [3:0]  mdl_next [NSlot];
  logic [3:0]  mdl_prev [NSlot];
  logic [31:0] mdl_ident [NSlot];
  int          mdl_total;
  logic [3:0]  mdl_cur;
  logic        mdl_cur_valid;
  logic [15:0] mdl_gen;
  logic [31:0] mdl_time;

  sched_cmd_t pending_cmds[$];
  sched_ans_t expected_answers[$];
  int fail_count = 0;
  int answers_seen = 0;
  int sender_idle_pct = 25;
  int ops_sent [8];

  // pick the next thread to run by walking the ring after the running one
  function automatic void pick_next_thread();
    int best;
    logic [3:0] walk, pick;
    logic found;
    best = 256;
    walk = mdl_cur;
    pick = mdl_cur;
    found = 1'b0;
    for (int i = 0; i < mdl_total; i++) begin
      walk = mdl_next[walk];
      if (!mdl_blocked[walk] && !mdl_asleep[walk] && int'(mdl_prio[walk]) < best) begin
        pick = walk;
        best = mdl_prio[walk];
        found = 1'b1;
      end
    end
    // running thread was killed and nobody is ready: its successor runs
    if (!found && !mdl_alive[mdl_cur]) pick = mdl_next[mdl_cur];
    mdl_cur = pick;
  endfunction

  function automatic void drop_thread(logic [3:0] s);
    mdl_alive[s] = 1'b0;
    mdl_next[mdl_prev[s]] = mdl_next[s];
    mdl_prev[mdl_next[s]] = mdl_prev[s];
    mdl_total--;
  endfunction

  function automatic logic find_thread(logic [31:0] id, output logic [3:0] where);
    logic [3:0] walk;
    walk = mdl_cur;
    where = '0;
    for (int i = 0; i < mdl_total; i++) begin
      if (mdl_ident[walk] == id) begin
        where = walk;
        return 1'b1;
      end
      walk = mdl_next[walk];
    end
    return 1'b0;
  endfunction

  function automatic sched_ans_t predict_answer(sched_cmd_t c);
    sched_ans_t a;
    logic [3:0] s, cs;
    a = '0;
    a.status = prrts_pkg::ST_OK;
    s = '0;
    case (c.opcode)
      prrts_pkg::OP_ADD: begin
        if (mdl_total >= NSlot) a.status = prrts_pkg::ST_FULL;
        else if (c.prio > mdl_max_prio) a.status = prrts_pkg::ST_BADPRIO;
        else begin
          while (s < NSlot - 1 && mdl_alive[s]) s++;
          if (!mdl_cur_valid) begin
            mdl_next[s] = s;
            mdl_prev[s] = s;
            mdl_cur = s;
            mdl_cur_valid = 1'b1;
          end else begin
            cs = mdl_cur;
            mdl_next[mdl_prev[cs]] = s;
            mdl_prev[s] = mdl_prev[cs];
            mdl_next[s] = cs;
            mdl_prev[cs] = s;
          end
          mdl_alive[s] = 1'b1;
          mdl_blocked[s] = 1'b0;
          mdl_asleep[s] = 1'b0;
          mdl_wake[s] = '0;
          mdl_prio[s] = c.prio;
          mdl_ident[s] = {mdl_gen, 12'd0, s};
          mdl_gen++;
          mdl_total++;
          a.added = mdl_ident[s];
        end
      end
      prrts_pkg::OP_KILL_ID: begin
        if (mdl_total < 2) a.status = prrts_pkg::ST_NOKILL;
        else if (!find_thread(c.target, s)) a.status = prrts_pkg::ST_NOTHREAD;
        else begin
          drop_thread(s);
          if (s == mdl_cur) pick_next_thread();
        end
      end
      prrts_pkg::OP_KILL_CUR: begin
        if (!mdl_cur_valid) a.status = prrts_pkg::ST_EMPTY;
        else if (mdl_total < 2) a.status = prrts_pkg::ST_NOKILL;
        else begin
          drop_thread(mdl_cur);
          pick_next_thread();
        end
      end
      prrts_pkg::OP_SLEEP: begin
        if (!mdl_cur_valid) a.status = prrts_pkg::ST_EMPTY;
        else begin
          mdl_wake[mdl_cur] = mdl_time + c.ticks;
          mdl_asleep[mdl_cur] = 1'b1;
          pick_next_thread();
        end
      end
      prrts_pkg::OP_BLOCK: begin
        if (!mdl_cur_valid) a.status = prrts_pkg::ST_EMPTY;
        else if (!find_thread(c.target, s)) a.status = prrts_pkg::ST_NOTHREAD;
        else mdl_blocked[s] = c.flag;
      end
      prrts_pkg::OP_TICK: begin
        mdl_time++;
        if (!mdl_cur_valid) a.status = prrts_pkg::ST_EMPTY;
        else begin
          s = mdl_cur;
          for (int i = 0; i < mdl_total; i++) begin
            if (mdl_asleep[s] && mdl_wake[s] == mdl_time) mdl_asleep[s] = 1'b0;
            s = mdl_next[s];
          end
          pick_next_thread();
        end
      end
      prrts_pkg::OP_SCHED: begin
        if (!mdl_cur_valid) a.status = prrts_pkg::ST_EMPTY;
        else pick_next_thread();
      end
      default: ;
    endcase
    a.run_valid = mdl_cur_valid;
    a.run_slot = mdl_cur_valid ? mdl_cur : 4'd0;
    a.run_id = mdl_cur_valid ? mdl_ident[mdl_cur] : 32'd0;
    return a;
  endfunction

  // a random live thread id most of the time, otherwise noise or a stale id
  function automatic logic [31:0] pick_target();
    logic [31:0] id;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7 && mdl_total > 0) begin
      id = mdl_ident[mdl_cur];
      for (int i = $urandom_range(0, mdl_total - 1); i > 0; i--)
        id = mdl_ident[mdl_next[id[3:0]]];
      return id;
    end
    if (k == 9) return $urandom();
    return {16'($urandom_range(0, 3)), 12'd0, 4'($urandom_range(0, 15))};
  endfunction

  function automatic sched_cmd_t make_cmd(logic [2:0] op, logic [7:0] p, logic [31:0] t,
                                         logic [31:0] k, logic f);
    sched_cmd_t c;
    c.opcode = op;
    c.prio = p;
    c.target = t;
    c.ticks = k;
    c.flag = f;
    return c;
  endfunction

  // driver: present the queue head, drop it once start meets busy low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
      end
      if ((!start || !busy) && pending_cmds.size() > 0
          && (start && !busy ? pending_cmds.size() > 0 : 1'b1)) begin
        if ($urandom_range(0, 99) >= sender_idle_pct) begin
          start <= 1'b1;
          opcode_i <= pending_cmds[0].opcode;
          priority_req_i <= pending_cmds[0].prio;
          target_id_i <= pending_cmds[0].target;
          sleep_ticks_i <= pending_cmds[0].ticks;
          block_flag_i <= pending_cmds[0].flag;
        end else begin
          start <= 1'b0;
        end
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each done pulse is one result transfer, checked against the oldest expectation
  always @(posedge clk_i) begin
    sched_ans_t exp_ans;
    if (rst_ni && done_o) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (status_o !== exp_ans.status) begin
          $error("status exp %0d got %0d", exp_ans.status, status_o);
          fail_count++;
        end
        if (running_slot_o !== exp_ans.run_slot) begin
          $error("running_slot exp %0d got %0d", exp_ans.run_slot, running_slot_o);
          fail_count++;
        end
        if (running_valid_o !== exp_ans.run_valid) begin
          $error("running_valid exp %0d got %0d", exp_ans.run_valid, running_valid_o);
          fail_count++;
        end
        if (running_thread_id_o !== exp_ans.run_id) begin
          $error("running_thread_id exp %h got %h", exp_ans.run_id, running_thread_id_o);
          fail_count++;
        end
        if (added_id_o !== exp_ans.added) begin
          $error("added_id exp %h got %h", exp_ans.added, added_id_o);
          fail_count++;
        end
      end
    end
  end

  // every command is predicted when queued, since the block takes them in order
  task automatic queue_cmd(sched_cmd_t c);
    pending_cmds.push_back(c);
    expected_answers.push_back(predict_answer(c));
    ops_sent[c.opcode]++;
  endtask

  task automatic drain_block();
    while (pending_cmds.size() > 0 || expected_answers.size() > 0 || start)
      @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_max_prio(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_max_prio = v;
  endtask

  // random traffic: mostly live ids, small tick counts so sleepers wake
  task automatic random_phase(int n);
    logic [2:0] op;
    int w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 22) op = prrts_pkg::OP_ADD;
      else if (w < 32) op = prrts_pkg::OP_KILL_ID;
      else if (w < 40) op = prrts_pkg::OP_KILL_CUR;
      else if (w < 52) op = prrts_pkg::OP_SLEEP;
      else if (w < 64) op = prrts_pkg::OP_BLOCK;
      else if (w < 84) op = prrts_pkg::OP_TICK;
      else if (w < 98) op = prrts_pkg::OP_SCHED;
      else op = OpUnused;
      queue_cmd(make_cmd(op,
          $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 7)),
          pick_target(),
          $urandom_range(0, 15) == 0 ? $urandom() : 32'($urandom_range(0, 6)),
          1'($urandom_range(0, 1))));
      while (pending_cmds.size() > 4) @(posedge clk_i);
    end
  endtask

  initial begin
    mdl_max_prio = 8'd255;
    for (int i = 0; i < NSlot; i++) begin
      mdl_alive[i] = 1'b0;
      mdl_prio[i] = '0;
      mdl_blocked[i] = 1'b0;
      mdl_asleep[i] = 1'b0;
      mdl_wake[i] = '0;
      mdl_next[i] = '0;
      mdl_prev[i] = '0;
      mdl_ident[i] = '0;
    end
    mdl_total = 0;
    mdl_cur = '0;
    mdl_cur_valid = 1'b0;
    mdl_gen = '0;
    mdl_time = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-table errors, extremes of each field, table full, kills
    queue_cmd(make_cmd(prrts_pkg::OP_KILL_CUR, 8'd0, 32'd0, 32'd0, 1'b0));
    queue_cmd(make_cmd(prrts_pkg::OP_SLEEP, 8'd0, 32'd0, 32'hffffffff, 1'b0));
    queue_cmd(make_cmd(prrts_pkg::OP_BLOCK, 8'd0, 32'd0, 32'd0, 1'b1));
    queue_cmd(make_cmd(prrts_pkg::OP_TICK, 8'd0, 32'd0, 32'd0, 1'b0));
    queue_cmd(make_cmd(prrts_pkg::OP_SCHED, 8'd0, 32'd0, 32'd0, 1'b0));
    queue_cmd(make_cmd(OpUnused, 8'hff, 32'hffffffff, 32'hffffffff, 1'b1));
    queue_cmd(make_cmd(prrts_pkg::OP_ADD, 8'd255, 32'd0, 32'd0, 1'b0));
    queue_cmd(make_cmd(prrts_pkg::OP_KILL_ID, 8'd0, 32'd0, 32'd0, 1'b0));   // lone thread
    queue_cmd(make_cmd(prrts_pkg::OP_KILL_CUR, 8'd0, 32'd0, 32'd0, 1'b0));  // lone thread
    for (int i = 0; i < 15; i++)
      queue_cmd(make_cmd(prrts_pkg::OP_ADD, 8'(i % 3), 32'd0, 32'd0, 1'b0));
    queue_cmd(make_cmd(prrts_pkg::OP_ADD, 8'd0, 32'd0, 32'd0, 1'b0));        // table full
    queue_cmd(make_cmd(prrts_pkg::OP_KILL_ID, 8'd0, 32'hffffffff, 32'd0, 1'b0)); // unknown id
    queue_cmd(make_cmd(prrts_pkg::OP_KILL_ID, 8'd0, 32'h0001_0001, 32'd0, 1'b0));
    drain_block();

    write_max_prio(8'd0);
    queue_cmd(make_cmd(prrts_pkg::OP_ADD, 8'd1, 32'd0, 32'd0, 1'b0));        // bad priority
    queue_cmd(make_cmd(prrts_pkg::OP_ADD, 8'd0, 32'd0, 32'd0, 1'b0));
    drain_block();

    write_max_prio(8'd5);
    random_phase(270);
    drain_block();
    sender_idle_pct = 45;
    write_max_prio(8'd255);
    random_phase(270);
    drain_block();
    sender_idle_pct = 0;
    write_max_prio(8'd3);
    random_phase(260);
    drain_block();

    $display("tb: %0d results checked; ops add %0d kill %0d/%0d sleep %0d block %0d",
             answers_seen, ops_sent[prrts_pkg::OP_ADD], ops_sent[prrts_pkg::OP_KILL_ID],
             ops_sent[prrts_pkg::OP_KILL_CUR], ops_sent[prrts_pkg::OP_SLEEP],
             ops_sent[prrts_pkg::OP_BLOCK]);
    $display("tb: tick %0d schedule %0d unused %0d, three priority ceilings",
             ops_sent[prrts_pkg::OP_TICK], ops_sent[prrts_pkg::OP_SCHED], ops_sent[OpUnused]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
